// ===== rtl/aes_pkg.sv =====
`default_nettype none

package aes_pkg;

   localparam int unsigned DATA_W  = 64;
   localparam int unsigned BLOCK_W = 128;
   localparam int unsigned ROWS    = 15;
   localparam int unsigned ROW_W   = 4;
   localparam int unsigned IDX_W   = 6;
   localparam int unsigned ADDR_W  = 6;

   typedef enum logic [2:0] {
      REG_KEY_WORD0   = 3'd0,
      REG_KEY_WORD1   = 3'd1,
      REG_KEY_WORD2   = 3'd2,
      REG_KEY_WORD3   = 3'd3,
      REG_KEY_LENGTH  = 3'd4,
      REG_DECRYPT     = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      KEY_LEN_128 = 2'd0,
      KEY_LEN_192 = 2'd1,
      KEY_LEN_256 = 2'd2
   } key_len_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_KEY0,
      ST_ADD0,
      ST_ROUND
   } state_type;

   localparam logic [7:0] POLY_REDUCE = 8'h1b;

   localparam logic [0:255][7:0] SBOX_TABLE = 2048'h
637c777bf26b6fc53001672bfed7ab76ca82c97dfa5947f0add4a2af9ca472c0b7fd9326363ff7cc34a5e5f171d83115_04c723c31896059a071280e2eb27b27509832c1a1b6e5aa0523bd6b329e32f8453d100ed20fcb15b6acbbe394a4c58cf_d0efaafb434d338545f9027f503c9fa851a3408f929d38f5bcb6da2110fff3d2cd0c13ec5f974417c4a77e3d645d1973_60814fdc222a908846eeb814de5e0bdbe0323a0a4906245cc2d3ac629195e479e7c8376d8dd54ea96c56f4ea657aae08_ba78252e1ca6b4c6e8dd741f4bbd8b8a703eb5664803f60e613557b986c11d9ee1f8981169d98e949b1e87e9ce5528df_8ca1890dbfe6426841992d0fb054bb16;

   function automatic logic [0:255][7:0] build_inv_sbox();
      logic [0:255][7:0] t;
      t = '0;
      for (int i = 0; i < 256; i++) begin
         t[SBOX_TABLE[i]] = 8'(i);
      end
      return t;
   endfunction

   localparam logic [0:255][7:0] INV_SBOX_TABLE = build_inv_sbox();

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? POLY_REDUCE : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      logic [31:0] r;
      for (int k = 0; k < 4; k++) begin
         r[8*k +: 8] = SBOX_TABLE[w[8*k +: 8]];
      end
      return r;
   endfunction

   function automatic logic [31:0] mix_word(input logic [31:0] w);
      logic [7:0] a0, a1, a2, a3;
      a0 = w[7:0];
      a1 = w[15:8];
      a2 = w[23:16];
      a3 = w[31:24];
      return {xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3),
              a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
              a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
              xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3};
   endfunction

   // Multiplies by 0e, 0b, 0d and 09 from the doubled, quadrupled and octupled byte.
   function automatic logic [31:0] inv_mix_word(input logic [31:0] w);
      logic [3:0][7:0] a, x2, x4, x8, m9, mb, md, me;
      a = w;
      for (int k = 0; k < 4; k++) begin
         x2[k] = xtime(a[k]);
         x4[k] = xtime(x2[k]);
         x8[k] = xtime(x4[k]);
         m9[k] = x8[k] ^ a[k];
         mb[k] = x8[k] ^ x2[k] ^ a[k];
         md[k] = x8[k] ^ x4[k] ^ a[k];
         me[k] = x8[k] ^ x4[k] ^ x2[k];
      end
      return {mb[0] ^ md[1] ^ m9[2] ^ me[3],
              md[0] ^ m9[1] ^ me[2] ^ mb[3],
              m9[0] ^ me[1] ^ mb[2] ^ md[3],
              me[0] ^ mb[1] ^ md[2] ^ m9[3]};
   endfunction

   // One cipher round without the key addition; the last round skips the column mix.
   function automatic logic [127:0] cipher_round(input logic [127:0] st, input logic inv,
                                                 input logic last);
      logic [127:0] sb, sh, mx;
      logic [1:0]   from;
      for (int i = 0; i < 16; i++) begin
         sb[8*i +: 8] = inv ? INV_SBOX_TABLE[st[8*i +: 8]] : SBOX_TABLE[st[8*i +: 8]];
      end
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            from = inv ? 2'(c - r) : 2'(c + r);
            sh[8*(r + 4*c) +: 8] = sb[8*r + 32*from +: 8];
         end
      end
      for (int c = 0; c < 4; c++) begin
         mx[32*c +: 32] = inv ? inv_mix_word(sh[32*c +: 32]) : mix_word(sh[32*c +: 32]);
      end
      return last ? sh : mx;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/aes_block_cipher.sv =====
`default_nettype none
// AES-128/192/256 block cipher, one round per cycle on a shared round unit.
// The first block after reset or a register write first expands 4*(nr+1) key schedule words
// (44, 52 or 60; nr = 10, 12 or 14), then every block runs ST_KEY0, ST_ADD0 and nr ST_ROUND steps.
// A new block is taken only in ST_IDLE; busy stays high until the result strobe rises.
// The result beat is shown for one cycle on rsp_valid; the receiver cannot stall it.
// Synchronous active-high reset zeroes the key registers, marks the key stale and idles.
module aes_block_cipher (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [aes_pkg::DATA_W-1:0]  req_block_low,
   input  wire logic [aes_pkg::DATA_W-1:0]  req_block_high,
   output logic                             rsp_valid,
   output logic [aes_pkg::DATA_W-1:0]       rsp_result_low,
   output logic [aes_pkg::DATA_W-1:0]       rsp_result_high,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [aes_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [aes_pkg::DATA_W-1:0]  pwdata,
   output logic [aes_pkg::DATA_W-1:0]       prdata,
   output logic                             pready
);
   import aes_pkg::*;

   logic [3:0][DATA_W-1:0] key_word_ff;
   logic [1:0]             key_len_ff;
   logic                   decrypt_ff;
   logic                   stale_ff;
   reg_index_type          reg_idx;
   logic                   csr_write;

   state_type              state_ff, state_in;
   logic [BLOCK_W-1:0]     blk_ff, blk_in;
   logic [3:0]             rnd_ff, rnd_in;
   logic [IDX_W-1:0]       kidx_ff, kidx_in;
   logic [2:0]             kmod_ff, kmod_in;
   logic [7:0]             rc_ff, rc_in;
   logic [7:0][31:0]       hist_ff, hist_in;
   logic [2:0][31:0]       rowbuf_ff, rowbuf_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_W-1:0]     rsp_ff, rsp_in;

   logic [BLOCK_W-1:0]     rk_mem [0:ROWS-1];
   logic [BLOCK_W-1:0]     rk_q_ff;
   logic [ROW_W-1:0]       rd_addr;
   logic                   wr_en;
   logic [ROW_W-1:0]       wr_addr;
   logic [BLOCK_W-1:0]     wr_data;

   logic [3:0]             nr;
   logic [2:0]             nk_m1;
   logic [31:0]            new_word, tmp_word, key_half;
   logic [ROW_W-1:0]       row;
   logic [BLOCK_W-1:0]     row_words;

   assign reg_idx   = reg_index_type'(paddr[5:3]);
   assign csr_write = psel & penable & pwrite;
   assign pready    = 1'b1;

   always_comb begin
      case (reg_idx)
         REG_KEY_WORD0:  prdata = key_word_ff[0];
         REG_KEY_WORD1:  prdata = key_word_ff[1];
         REG_KEY_WORD2:  prdata = key_word_ff[2];
         REG_KEY_WORD3:  prdata = key_word_ff[3];
         REG_KEY_LENGTH: prdata = {{(DATA_W-2){1'b0}}, key_len_ff};
         REG_DECRYPT:    prdata = {{(DATA_W-1){1'b0}}, decrypt_ff};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_word_ff <= '0;
         key_len_ff  <= '0;
         decrypt_ff  <= 1'b0;
         stale_ff    <= 1'b1;
      end else begin
         if (csr_write) begin
            case (reg_idx)
               REG_KEY_WORD0:  key_word_ff[0] <= pwdata;
               REG_KEY_WORD1:  key_word_ff[1] <= pwdata;
               REG_KEY_WORD2:  key_word_ff[2] <= pwdata;
               REG_KEY_WORD3:  key_word_ff[3] <= pwdata;
               REG_KEY_LENGTH: key_len_ff     <= pwdata[1:0];
               REG_DECRYPT:    decrypt_ff     <= pwdata[0];
               default:        ;
            endcase
         end
         if (csr_write && (reg_idx == REG_KEY_WORD0 || reg_idx == REG_KEY_WORD1 ||
                           reg_idx == REG_KEY_WORD2 || reg_idx == REG_KEY_WORD3 ||
                           reg_idx == REG_KEY_LENGTH || reg_idx == REG_DECRYPT)) begin
            stale_ff <= 1'b1;
         end else if (state_ff == ST_IDLE && start && stale_ff) begin
            stale_ff <= 1'b0;
         end
      end
   end

   // A key length code of three runs as a 256-bit key.
   always_comb begin
      case (key_len_ff)
         KEY_LEN_128: begin
            nr    = 4'd10;
            nk_m1 = 3'd3;
         end
         KEY_LEN_192: begin
            nr    = 4'd12;
            nk_m1 = 3'd5;
         end
         default: begin
            nr    = 4'd14;
            nk_m1 = 3'd7;
         end
      endcase
   end

   // Expansion datapath: one key schedule word per cycle from a window of the last eight.
   always_comb begin
      key_half = kidx_ff[0] ? key_word_ff[kidx_ff[2:1]][63:32]
                            : key_word_ff[kidx_ff[2:1]][31:0];
      tmp_word = hist_ff[0];
      if (kmod_ff == 3'd0) begin
         tmp_word = sub_word({hist_ff[0][7:0], hist_ff[0][31:8]}) ^ {24'd0, rc_ff};
      end else if (nk_m1 == 3'd7 && kmod_ff == 3'd4) begin
         tmp_word = sub_word(hist_ff[0]);
      end
      if (kidx_ff <= IDX_W'(nk_m1)) begin
         new_word = key_half;
      end else begin
         new_word = hist_ff[nk_m1] ^ tmp_word;
      end
      row       = kidx_ff[5:2];
      row_words = {new_word, rowbuf_ff[2], rowbuf_ff[1], rowbuf_ff[0]};
      wr_en     = (state_ff == ST_EXPAND) && (kidx_ff[1:0] == 2'd3);
      wr_addr   = row;
      wr_data   = row_words;
      if (decrypt_ff) begin
         wr_addr = nr - row;
         if (row != 4'd0 && row != nr) begin
            for (int c = 0; c < 4; c++) begin
               wr_data[32*c +: 32] = inv_mix_word(row_words[32*c +: 32]);
            end
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      blk_in       = blk_ff;
      rnd_in       = rnd_ff;
      kidx_in      = kidx_ff;
      kmod_in      = kmod_ff;
      rc_in        = rc_ff;
      hist_in      = hist_ff;
      rowbuf_in    = rowbuf_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_addr      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               blk_in  = {req_block_high, req_block_low};
               kidx_in = '0;
               kmod_in = '0;
               rc_in   = 8'h01;
               state_in = stale_ff ? ST_EXPAND : ST_KEY0;
            end
         end
         ST_EXPAND: begin
            hist_in   = {hist_ff[6:0], new_word};
            rowbuf_in = {new_word, rowbuf_ff[2:1]};
            kidx_in   = kidx_ff + IDX_W'(1);
            kmod_in   = (kmod_ff == nk_m1) ? 3'd0 : kmod_ff + 3'd1;
            if (kidx_ff > IDX_W'(nk_m1) && kmod_ff == 3'd0) begin
               rc_in = xtime(rc_ff);
            end
            if (kidx_ff[1:0] == 2'd3 && row == nr) begin
               state_in = ST_KEY0;
            end
         end
         ST_KEY0: begin
            rd_addr  = '0;
            state_in = ST_ADD0;
         end
         ST_ADD0: begin
            blk_in   = blk_ff ^ rk_q_ff;
            rd_addr  = 4'd1;
            rnd_in   = 4'd1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            blk_in  = cipher_round(blk_ff, decrypt_ff, rnd_ff == nr) ^ rk_q_ff;
            rd_addr = (rnd_ff == nr) ? 4'd0 : rnd_ff + 4'd1;
            rnd_in  = rnd_ff + 4'd1;
            if (rnd_ff == nr) begin
               rsp_in       = blk_in;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff    <= blk_in;
      rnd_ff    <= rnd_in;
      kidx_ff   <= kidx_in;
      kmod_ff   <= kmod_in;
      rc_ff     <= rc_in;
      hist_ff   <= hist_in;
      rowbuf_ff <= rowbuf_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rk_mem[wr_addr] <= wr_data;
      end
      rk_q_ff <= rk_mem[rd_addr];
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_low  = rsp_ff[63:0];
   assign rsp_result_high = rsp_ff[127:64];

endmodule

`default_nettype wire
